/* design/blea_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the control-store program for the Birks layer
// energy accumulator. Depends on nothing; every other file imports it.
package blea_pkg;

  // Geometry and field widths.
  localparam int LAYER_COUNT = 128;
  localparam int LAYER_AW    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int KIND_W      = 2;
  localparam int E_W         = 24;
  localparam int L_W         = 20;
  localparam int CHG_W       = 4;
  localparam int IDX_W       = 8;
  localparam int SUM_W       = 32;
  localparam int COEF_W      = 20;
  localparam int EML_W       = 8;
  localparam int FRAC_W      = 16;

  // Divider widths: product E*L, denominator (L << 16) + coef*E with a carry bit.
  localparam int PROD_W = E_W + L_W;
  localparam int DEN_W  = PROD_W + 1;
  localparam int QCNT_W = $clog2(E_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_BIRKS_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIRKS_COEF   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EM_LAYERS    = CFG_IDX_W'(2);

  localparam logic              BIRKS_ENABLE_RST = 1'b1;
  localparam logic [COEF_W-1:0] BIRKS_COEF_RST   = COEF_W'(8258);
  localparam logic [EML_W-1:0]  EM_LAYERS_RST    = EML_W'(16);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_HIT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // Microcode: datapath operations, jump conditions, control word.
  localparam int PC_W = 3;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_CAPTURE  = 3'd1,
    OP_MUL      = 3'd2,
    OP_DIV_INIT = 3'd3,
    OP_DIV_STEP = 3'd4,
    OP_COMMIT   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_NO_BEAT  = 3'd1,
    COND_NOT_HIT  = 3'd2,
    COND_BYPASS   = 3'd3,
    COND_DIV_MORE = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] STEP_WAIT     = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_MUL      = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_DIV_INIT = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_DIV_LOOP = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_OUT_WAIT = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_COMMIT   = PC_W'(5);

  // The program. A taken condition jumps to target, otherwise the step
  // counter advances by one.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      STEP_WAIT:     w = '{op: OP_CAPTURE,  cond: COND_NO_BEAT,  target: STEP_WAIT};
      STEP_MUL:      w = '{op: OP_MUL,      cond: COND_NOT_HIT,  target: STEP_OUT_WAIT};
      STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_BYPASS,   target: STEP_OUT_WAIT};
      STEP_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIV_LOOP};
      STEP_OUT_WAIT: w = '{op: OP_NONE,     cond: COND_OUT_BUSY, target: STEP_OUT_WAIT};
      STEP_COMMIT:   w = '{op: OP_COMMIT,   cond: COND_ALWAYS,   target: STEP_WAIT};
      default:       w = '{op: OP_NONE,     cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

  // Decoded strobes from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic div_init;
    logic div_step;
    logic commit;
  } ctrl_t;

  // Flags from the datapath that the jump conditions test.
  typedef struct packed {
    logic in_valid;
    logic not_hit;
    logic bypass;
    logic div_more;
    logic out_busy;
  } status_t;

  // Unsigned add that sticks at all ones.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

/* design/blea_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for hit items and for result items.
// Depends on blea_pkg for the field widths.
interface blea_in_if;
  import blea_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [E_W-1:0]          energy_deposit;
  logic [L_W-1:0]          track_len;
  logic signed [CHG_W-1:0] hit_charge;
  logic [IDX_W-1:0]        layer_index;

  modport source(output valid, kind, energy_deposit, track_len, hit_charge,
                 layer_index, input ready);
  modport sink(input valid, kind, energy_deposit, track_len, hit_charge,
               layer_index, output ready);
endinterface

interface blea_out_if;
  import blea_pkg::*;
  logic             valid;
  logic             ready;
  logic [E_W-1:0]   corrected_energy;
  logic [SUM_W-1:0] layer_total;
  logic [SUM_W-1:0] em_total;
  logic [SUM_W-1:0] had_total;
  logic             range_error;

  modport source(output valid, corrected_energy, layer_total, em_total, had_total,
                 range_error, input ready);
  modport sink(input valid, corrected_energy, layer_total, em_total, had_total,
               range_error, output ready);
endinterface

/* design/blea_seq.sv */
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control-store lookup, conditional jumps.
// Depends on blea_pkg for the program and the control and status structs.
module blea_seq (
  input  logic              clk,
  input  logic              rst,
  input  blea_pkg::status_t status,
  output blea_pkg::ctrl_t   ctrl
);
  import blea_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          uw;
  logic            take;

  assign uw = ucode_rom(pc);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   take = 1'b1;
      COND_NO_BEAT:  take = !status.in_valid;
      COND_NOT_HIT:  take = status.not_hit;
      COND_BYPASS:   take = status.bypass;
      COND_DIV_MORE: take = status.div_more;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Decode the operation field into datapath strobes.
  always_comb begin
    ctrl = '0;
    unique case (uw.op)
      OP_NONE:     ctrl = '0;
      OP_CAPTURE:  ctrl.capture = 1'b1;
      OP_MUL:      ctrl.mul = 1'b1;
      OP_DIV_INIT: ctrl.div_init = 1'b1;
      OP_DIV_STEP: ctrl.div_step = 1'b1;
      OP_COMMIT:   ctrl.commit = 1'b1;
      default:     ctrl = '0;
    endcase
  end

endmodule

/* design/blea_div.sv */
`timescale 1ns / 1ps
// Birks quench unit: two registered multiplies, then a restoring divide that
// yields one quotient bit per step. Depends on blea_pkg.
module blea_div (
  input  logic                        clk,
  input  blea_pkg::ctrl_t             ctrl,
  input  logic [blea_pkg::E_W-1:0]    energy,
  input  logic [blea_pkg::L_W-1:0]    len,
  input  logic [blea_pkg::CHG_W-1:0]  charge,
  input  logic                        birks_enable,
  input  logic [blea_pkg::COEF_W-1:0] birks_coef,
  output logic [blea_pkg::E_W-1:0]    quot,
  output logic                        bypass,
  output logic                        div_more
);
  import blea_pkg::*;

  localparam int SHIFT_LO = E_W - FRAC_W;

  logic [PROD_W-1:0] prod_el;
  logic [PROD_W-1:0] prod_ce;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [E_W-1:0]    num_lo;
  logic [QCNT_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic              fits;

  // The correction is skipped when disabled or when energy, length or charge is zero.
  assign bypass   = !birks_enable || (energy == '0) || (len == '0) || (charge == '0);
  assign div_more = (cnt != QCNT_W'(E_W - 1));

  // Shift in the next numerator bit and test against the denominator.
  assign trial = {rem, num_lo[E_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod_el <= PROD_W'(energy) * PROD_W'(len);
      prod_ce <= PROD_W'(birks_coef) * PROD_W'(energy);
    end
    // The numerator is E*L*2^16; the quotient is known to fit in E_W bits,
    // so the top part of the numerator already sits below the denominator.
    if (ctrl.div_init) begin
      den    <= DEN_W'({len, {FRAC_W{1'b0}}}) + DEN_W'(prod_ce);
      rem    <= DEN_W'(prod_el[PROD_W-1:SHIFT_LO]);
      num_lo <= {prod_el[SHIFT_LO-1:0], {FRAC_W{1'b0}}};
      quot   <= energy;
      cnt    <= '0;
    end
    if (ctrl.div_step) begin
      rem    <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      num_lo <= {num_lo[E_W-2:0], 1'b0};
      quot   <= {quot[E_W-2:0], fits};
      cnt    <= cnt + QCNT_W'(1);
    end
  end

endmodule

/* design/blea_acc.sv */
`timescale 1ns / 1ps
// Layer sum memory with per-layer valid bits, EM and HAD section sums, and
// the output register of the result channel. Depends on blea_pkg, blea_if.
module blea_acc (
  input  logic                       clk,
  input  logic                       rst,
  input  blea_pkg::ctrl_t            ctrl,
  input  blea_pkg::kind_t            kind,
  input  logic [blea_pkg::IDX_W-1:0] layer_index,
  input  logic [blea_pkg::E_W-1:0]   corr,
  input  logic [blea_pkg::EML_W-1:0] em_layers,
  output logic                       out_busy,
  blea_out_if.source                 results
);
  import blea_pkg::*;

  logic [SUM_W-1:0]       mem [LAYER_COUNT];
  logic [SUM_W-1:0]       rdata;
  logic [LAYER_COUNT-1:0] valid;
  logic [SUM_W-1:0]       em_sum;
  logic [SUM_W-1:0]       had_sum;
  logic [SUM_W-1:0]       em_sum_next;
  logic [SUM_W-1:0]       had_sum_next;

  logic [LAYER_AW-1:0] addr;
  logic                in_range;
  logic                is_em;
  logic [SUM_W-1:0]    cur;
  logic [SUM_W-1:0]    layer_new;
  logic [SUM_W-1:0]    corr_ext;
  logic                mem_we;
  logic                valid_set;
  logic                valid_clr;

  logic             out_valid;
  logic [E_W-1:0]   res_corr;
  logic [SUM_W-1:0] res_layer;
  logic [SUM_W-1:0] res_em;
  logic [SUM_W-1:0] res_had;
  logic             res_err;

  // Addressed layer and its current value; a layer without a valid bit is zero.
  assign addr      = layer_index[LAYER_AW-1:0];
  assign in_range  = ({1'b0, layer_index} < (IDX_W + 1)'(LAYER_COUNT));
  assign is_em     = (layer_index < em_layers);
  assign cur       = (in_range && valid[addr]) ? rdata : '0;
  assign corr_ext  = SUM_W'(corr);
  assign layer_new = sat_add(cur, corr_ext);
  assign out_busy  = out_valid && !results.ready;

  // Result fields and state updates for the item being committed.
  always_comb begin
    res_corr     = '0;
    res_layer    = '0;
    res_em       = em_sum;
    res_had      = had_sum;
    res_err      = 1'b0;
    em_sum_next  = em_sum;
    had_sum_next = had_sum;
    mem_we       = 1'b0;
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    unique case (kind)
      KIND_HIT: begin
        res_corr = corr;
        res_err  = !in_range;
        if (in_range) begin
          res_layer = layer_new;
          mem_we    = 1'b1;
          valid_set = 1'b1;
          if (is_em) begin
            em_sum_next = sat_add(em_sum, corr_ext);
          end else begin
            had_sum_next = sat_add(had_sum, corr_ext);
          end
        end
        res_em  = em_sum_next;
        res_had = had_sum_next;
      end
      KIND_CLEAR: begin
        valid_clr    = 1'b1;
        em_sum_next  = '0;
        had_sum_next = '0;
        res_em       = '0;
        res_had      = '0;
      end
      KIND_READ: begin
        res_layer = cur;
        res_err   = !in_range;
      end
      default: begin
        res_layer = '0;
      end
    endcase
  end

  // Layer memory: one port, read data registered every cycle.
  always_ff @(posedge clk) begin
    if (ctrl.commit && mem_we) begin
      mem[addr] <= layer_new;
    end
    rdata <= mem[addr];
  end

  // Valid bits and section sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      em_sum  <= '0;
      had_sum <= '0;
    end else if (ctrl.commit) begin
      if (valid_clr) begin
        valid <= '0;
      end else if (valid_set) begin
        valid[addr] <= 1'b1;
      end
      em_sum  <= em_sum_next;
      had_sum <= had_sum_next;
    end
  end

  // Output register; the sequencer commits only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      results.corrected_energy <= res_corr;
      results.layer_total      <= res_layer;
      results.em_total         <= res_em;
      results.had_total        <= res_had;
      results.range_error      <= res_err;
    end
  end

  assign results.valid = out_valid;

endmodule

/* design/birks_layer_energy_accumulator_core.sv */
`timescale 1ns / 1ps
// Top level of the Birks layer energy accumulator: configuration registers,
// input item register and the wiring of sequencer, quench unit and sums.
// Depends on blea_pkg, blea_if, blea_seq, blea_div and blea_acc.
//
//   Channel   Role    Beat contents
//   hits      sink    kind, energy_deposit, track_len, hit_charge, layer_index
//   results   source  corrected_energy, layer_total, em_total, had_total, range_error
//   cfg_*     write   cfg_write strobe, cfg_index, cfg_data
//
// A hit that needs the Birks correction goes from its beat to its result beat
// through capture, multiply, divide setup, 24 divide steps (one quotient bit
// each), output check and commit. A hit that skips the correction leaves out
// the divide steps, and any other item leaves out the divide setup as well.
// Items are handled one at a time; the next beat is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// Reset is synchronous; it clears the layer sums at once through the valid bits and zeroes the section sums.
// A stalled result holds the sequencer in its output check step.
module birks_layer_energy_accumulator_core (
  input  logic                            clk,
  input  logic                            rst,
  blea_in_if.sink                         hits,
  blea_out_if.source                      results,
  input  logic                            cfg_write,
  input  logic [blea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blea_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blea_pkg::*;

  logic              birks_enable;
  logic [COEF_W-1:0] birks_coef;
  logic [EML_W-1:0]  em_layers;

  kind_t            item_kind;
  logic [E_W-1:0]   item_energy;
  logic [L_W-1:0]   item_len;
  logic [CHG_W-1:0] item_charge;
  logic [IDX_W-1:0] item_index;

  ctrl_t          ctrl;
  status_t        status;
  logic [E_W-1:0] quot;
  logic           bypass;
  logic           div_more;
  logic           out_busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      birks_enable <= BIRKS_ENABLE_RST;
      birks_coef   <= BIRKS_COEF_RST;
      em_layers    <= EM_LAYERS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIRKS_ENABLE: birks_enable <= cfg_data[0];
        REG_BIRKS_COEF:   birks_coef   <= cfg_data[COEF_W-1:0];
        REG_EM_LAYERS:    em_layers    <= cfg_data[EML_W-1:0];
        default:          birks_enable <= birks_enable;
      endcase
    end
  end

  // Input item register, loaded on the accepted beat. No beat is taken in reset.
  assign hits.ready = ctrl.capture && !rst;

  always_ff @(posedge clk) begin
    if (hits.valid && hits.ready) begin
      item_kind   <= kind_t'(hits.kind);
      item_energy <= hits.energy_deposit;
      item_len    <= hits.track_len;
      item_charge <= hits.hit_charge;
      item_index  <= hits.layer_index;
    end
  end

  // Flags tested by the sequencer's jumps.
  always_comb begin
    status.in_valid = hits.valid;
    status.not_hit  = (item_kind != KIND_HIT);
    status.bypass   = bypass;
    status.div_more = div_more;
    status.out_busy = out_busy;
  end

  blea_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  blea_div u_div (
    .clk          (clk),
    .ctrl         (ctrl),
    .energy       (item_energy),
    .len          (item_len),
    .charge       (item_charge),
    .birks_enable (birks_enable),
    .birks_coef   (birks_coef),
    .quot         (quot),
    .bypass       (bypass),
    .div_more     (div_more)
  );

  blea_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .kind        (item_kind),
    .layer_index (item_index),
    .corr        (quot),
    .em_layers   (em_layers),
    .out_busy    (out_busy),
    .results     (results)
  );

endmodule
